// ===== hdl/adsm_pkg.sv =====
// Package: shared types and constants for the absolute-difference statistics block
package adsm_pkg;

	localparam int unsigned MAX_ITEMS  = 262144;
	localparam int unsigned DIV_STEPS  = 50;
	localparam int unsigned DIV_CW     = $clog2(DIV_STEPS);
	localparam int unsigned MUL_STEPS  = 16;
	localparam int unsigned MUL_CW     = $clog2(MUL_STEPS);
	localparam int unsigned SQRT_STEPS = 16;
	localparam int unsigned SQRT_CW    = $clog2(SQRT_STEPS);

	typedef enum logic [3:0] {
		ST_ACC,
		ST_S_GO,
		ST_S_WAIT,
		ST_Q_GO,
		ST_Q_WAIT,
		ST_M_GO,
		ST_M_WAIT,
		ST_T_GO,
		ST_T_WAIT,
		ST_FIX,
		ST_ADJ,
		ST_R_GO,
		ST_R_WAIT,
		ST_V_GO,
		ST_V_WAIT,
		ST_DONE
	} state_t;

endpackage

// ===== hdl/abs_difference_statistics.sv =====
// Top level: absolute-difference accumulator with serial mean, RMS, variance and std dev
// Finish: a last pair starts the serial divisions, multiply and roots that produce its result.
// Throughput: one pair per cycle while accumulating; no pair is taken during the finish, which runs
//   the three 50-step divisions, the 16-step multiply and two roots, nor until the output is free.
// Reset: arst_n clears the accumulators, the sequencer and the result valid flag.
module abs_difference_statistics (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [15:0] first_value,
	input  logic [15:0] second_value,
	input  logic        last,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [15:0] mean,
	output logic [15:0] root_mean_square,
	output logic [31:0] variance,
	output logic [15:0] std_dev,
	output logic [18:0] item_total,
	output logic        overflowed
);

	adsm_pkg::state_t    state_q, state_nxt;

	logic        div_start, div_done;
	logic        mul_start, mul_done;
	logic        sqrt_start, sqrt_done;

	logic [33:0] sum_q;
	logic [49:0] sq_sum_q;
	logic [18:0] count_q;
	logic        drop_q;
	logic [15:0] d;
	logic [31:0] d_sq;
	logic        take;
	logic        room;
	logic [18:0] count_nxt;

	logic [49:0] div_dividend;
	logic [49:0] div_quo;
	logic [18:0] div_rem;
	logic [50:0] mul_prod;
	logic [31:0] sqrt_in;
	logic [15:0] sqrt_root;

	logic [15:0] m_q;
	logic [18:0] r_q;
	logic [31:0] mean_sq_q;
	logic [49:0] t_q;
	logic [49:0] q1_q;
	logic [18:0] t1_q;
	logic [37:0] nt1_q;
	logic [37:0] rr_q;
	logic [31:0] var_q;
	logic [15:0] rms_q;
	logic [49:0] var_full;

	logic        res_valid_q;
	logic [15:0] mean_q, rmso_q, sdo_q;
	logic [31:0] varo_q;
	logic [18:0] total_q;
	logic        ovf_q;
	logic        out_free;

	assign d         = (first_value >= second_value) ? first_value - second_value
	                                                 : second_value - first_value;
	assign d_sq      = 32'(d) * 32'(d);
	assign take      = item_valid && item_ready;
	assign room      = count_q < 19'(adsm_pkg::MAX_ITEMS);
	assign count_nxt = room ? count_q + 1'b1 : count_q;
	assign out_free  = !res_valid_q || result_ready;
	assign var_full  = q1_q - 50'((nt1_q < rr_q) && (q1_q != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= adsm_pkg::ST_ACC;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			adsm_pkg::ST_ACC:
				if (take && last)
					state_nxt = (count_nxt == '0) ? adsm_pkg::ST_DONE : adsm_pkg::ST_S_GO;
			adsm_pkg::ST_S_GO:   state_nxt = adsm_pkg::ST_S_WAIT;
			adsm_pkg::ST_S_WAIT: if (div_done) state_nxt = adsm_pkg::ST_Q_GO;
			adsm_pkg::ST_Q_GO:   state_nxt = adsm_pkg::ST_Q_WAIT;
			adsm_pkg::ST_Q_WAIT: if (div_done) state_nxt = adsm_pkg::ST_M_GO;
			adsm_pkg::ST_M_GO:   state_nxt = adsm_pkg::ST_M_WAIT;
			adsm_pkg::ST_M_WAIT: if (mul_done) state_nxt = adsm_pkg::ST_T_GO;
			adsm_pkg::ST_T_GO:   state_nxt = adsm_pkg::ST_T_WAIT;
			adsm_pkg::ST_T_WAIT: if (div_done) state_nxt = adsm_pkg::ST_FIX;
			adsm_pkg::ST_FIX:    state_nxt = adsm_pkg::ST_ADJ;
			adsm_pkg::ST_ADJ:    state_nxt = adsm_pkg::ST_R_GO;
			adsm_pkg::ST_R_GO:   state_nxt = adsm_pkg::ST_R_WAIT;
			adsm_pkg::ST_R_WAIT: if (sqrt_done) state_nxt = adsm_pkg::ST_V_GO;
			adsm_pkg::ST_V_GO:   state_nxt = adsm_pkg::ST_V_WAIT;
			adsm_pkg::ST_V_WAIT: if (sqrt_done) state_nxt = adsm_pkg::ST_DONE;
			adsm_pkg::ST_DONE:   if (out_free) state_nxt = adsm_pkg::ST_ACC;
			default:             state_nxt = adsm_pkg::ST_ACC;
		endcase
	end

	always_comb begin
		item_ready = (state_q == adsm_pkg::ST_ACC);
		div_start  = (state_q == adsm_pkg::ST_S_GO) || (state_q == adsm_pkg::ST_Q_GO)
		          || (state_q == adsm_pkg::ST_T_GO);
		mul_start  = (state_q == adsm_pkg::ST_M_GO);
		sqrt_start = (state_q == adsm_pkg::ST_R_GO) || (state_q == adsm_pkg::ST_V_GO);
		unique case (state_q)
			adsm_pkg::ST_S_GO: div_dividend = {16'b0, sum_q};
			adsm_pkg::ST_Q_GO: div_dividend = sq_sum_q;
			default:           div_dividend = t_q;
		endcase
		sqrt_in = (state_q == adsm_pkg::ST_R_GO) ? mean_sq_q : var_q;
	end

	adsm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (count_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	adsm_mul u_mul (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (mul_start),
		.multiplier   (m_q),
		.multiplicand ({1'b0, sum_q} + {16'b0, r_q}),
		.done         (mul_done),
		.product      (mul_prod)
	);

	adsm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sqrt_in),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			sq_sum_q <= '0;
			count_q  <= '0;
			drop_q   <= 1'b0;
		end else if (take) begin
			if (room) begin
				sum_q    <= sum_q + 34'(d);
				sq_sum_q <= sq_sum_q + 50'(d_sq);
				count_q  <= count_nxt;
			end else begin
				drop_q <= 1'b1;
			end
		end else if (state_q == adsm_pkg::ST_DONE && out_free) begin
			sum_q    <= '0;
			sq_sum_q <= '0;
			count_q  <= '0;
			drop_q   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_done && state_q == adsm_pkg::ST_S_WAIT) begin
			m_q <= div_quo[15:0];
			r_q <= div_rem;
		end
		if (div_done && state_q == adsm_pkg::ST_Q_WAIT)
			mean_sq_q <= div_quo[31:0];
		if (mul_done)
			t_q <= sq_sum_q - mul_prod[49:0];
		if (div_done && state_q == adsm_pkg::ST_T_WAIT) begin
			q1_q <= div_quo;
			t1_q <= div_rem;
		end
		if (state_q == adsm_pkg::ST_FIX) begin
			nt1_q <= 38'(count_q) * 38'(t1_q);
			rr_q  <= 38'(r_q) * 38'(r_q);
		end
		if (state_q == adsm_pkg::ST_ADJ)
			var_q <= var_full[31:0];
		if (sqrt_done && state_q == adsm_pkg::ST_R_WAIT)
			rms_q <= sqrt_root;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (state_q == adsm_pkg::ST_DONE && out_free)
			res_valid_q <= 1'b1;
		else if (result_ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == adsm_pkg::ST_DONE && out_free) begin
			total_q <= count_q;
			ovf_q   <= drop_q;
			if (count_q == '0) begin
				mean_q <= '0;
				rmso_q <= '0;
				varo_q <= '0;
				sdo_q  <= '0;
			end else begin
				mean_q <= m_q;
				rmso_q <= rms_q;
				varo_q <= var_q;
				sdo_q  <= sqrt_root;
			end
		end
	end

	assign result_valid     = res_valid_q;
	assign mean             = mean_q;
	assign root_mean_square = rmso_q;
	assign variance         = varo_q;
	assign std_dev          = sdo_q;
	assign item_total       = total_q;
	assign overflowed       = ovf_q;

endmodule

// ===== hdl/adsm_div.sv =====
// Bit-serial restoring divider, 50-bit dividend by 19-bit divisor
module adsm_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [49:0]            dividend,
	input  logic [18:0]            divisor,
	output logic                   done,
	output logic [49:0]            quotient,
	output logic [18:0]            remainder
);

	logic                          busy_q;
	logic [adsm_pkg::DIV_CW-1:0]   cnt_q;
	logic [49:0]                   dvd_q;
	logic [18:0]                   rem_q;
	logic [18:0]                   dsr_q;
	logic                          done_q;
	logic [19:0]                   shifted;
	logic                          ge;
	logic [19:0]                   diff;

	assign shifted = {rem_q, dvd_q[49]};
	assign ge      = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == adsm_pkg::DIV_CW'(adsm_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[48:0], ge};
			rem_q <= ge ? diff[18:0] : shifted[18:0];
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

// ===== hdl/adsm_mul.sv =====
// Shift-and-add multiplier, 16-bit by 35-bit, one multiplier bit per cycle
module adsm_mul (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [15:0]            multiplier,
	input  logic [34:0]            multiplicand,
	output logic                   done,
	output logic [50:0]            product
);

	logic                          busy_q;
	logic [adsm_pkg::MUL_CW-1:0]   cnt_q;
	logic [15:0]                   mlt_q;
	logic [50:0]                   mcd_q;
	logic [50:0]                   acc_q;
	logic                          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == adsm_pkg::MUL_CW'(adsm_pkg::MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			mlt_q <= multiplier;
			mcd_q <= {16'b0, multiplicand};
			acc_q <= '0;
		end else if (busy_q) begin
			if (mlt_q[0])
				acc_q <= acc_q + mcd_q;
			mlt_q <= {1'b0, mlt_q[15:1]};
			mcd_q <= {mcd_q[49:0], 1'b0};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ===== hdl/adsm_sqrt.sv =====
// Digit-by-digit floor square root of a 32-bit value, two radicand bits per cycle
module adsm_sqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [31:0]            radicand,
	output logic                   done,
	output logic [15:0]            root
);

	logic                          busy_q;
	logic [adsm_pkg::SQRT_CW-1:0]  cnt_q;
	logic [31:0]                   rad_q;
	logic [16:0]                   rem_q;
	logic [15:0]                   root_q;
	logic                          done_q;
	logic [18:0]                   rem_sh;
	logic [18:0]                   trial;
	logic                          ge;
	logic [18:0]                   diff;

	assign rem_sh = {rem_q, rad_q[31:30]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign ge     = rem_sh >= trial;
	assign diff   = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == adsm_pkg::SQRT_CW'(adsm_pkg::SQRT_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[29:0], 2'b00};
			rem_q  <= ge ? diff[16:0] : rem_sh[16:0];
			root_q <= {root_q[14:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== hdl/adsm_checker.sv =====
// Port-level checker for the absolute-difference statistics block, with its bind
module adsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input logic [15:0] mean,
	input logic [15:0] root_mean_square,
	input logic [31:0] variance,
	input logic [15:0] std_dev,
	input logic [18:0] item_total
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(variance) && $stable(mean))
		else $error("result changed before transfer");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> item_total != '0)
		else $error("result with no counted pairs");

	a_rms: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> root_mean_square >= mean)
		else $error("rms below mean");

	a_sd: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ({16'b0, std_dev} * {16'b0, std_dev} <= variance)
			&& (({17'b0, std_dev} + 33'd1) * ({17'b0, std_dev} + 33'd1) > {1'b0, variance}))
		else $error("std dev is not the floor root of variance");

endmodule

bind abs_difference_statistics adsm_checker u_adsm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.result_valid     (result_valid),
	.result_ready     (result_ready),
	.mean             (mean),
	.root_mean_square (root_mean_square),
	.variance         (variance),
	.std_dev          (std_dev),
	.item_total       (item_total)
);

// ===== tb/testbench.sv =====
// Testbench for abs_difference_statistics: directed table and random sets checked against a predictor
`timescale 1ns / 100ps

module testbench;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic [15:0] first_value = '0;
	logic [15:0] second_value = '0;
	logic        last = 1'b0;
	logic        result_ready = 1'b0;
	logic        item_ready;
	logic        result_valid;
	logic [15:0] mean;
	logic [15:0] root_mean_square;
	logic [31:0] variance;
	logic [15:0] std_dev;
	logic [18:0] item_total;
	logic        overflowed;

	typedef struct packed {
		logic [15:0] mean;
		logic [15:0] rms;
		logic [31:0] var_q;
		logic [15:0] sd;
		logic [18:0] total;
		logic        ovf;
	} stats_t;

	typedef struct {
		logic [15:0] a;
		logic [15:0] b;
		logic        lst;
		logic        has_known;
		stats_t      known;
	} row_t;

	stats_t stats_queue[$];
	logic [63:0] acc_sum, acc_sq, acc_cnt;
	logic        acc_drop;
	int  errors = 0;
	int  send_idle = 0;
	int  recv_stall = 0;
	bit  hold_off = 0;
	row_t rows[$];

	always #5 clk = ~clk;

	abs_difference_statistics DUT (.*);

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else
				root >>= 1;
			bitv >>= 2;
		end
		return root;
	endfunction

	// returns 1 when the pair closes a set and fills res
	function automatic bit accumulate_pair(input logic [15:0] a, input logic [15:0] b,
			input logic lst, output stats_t res);
		logic [63:0] d, n, m, r, t, q1, t1;
		d = (a >= b) ? a - b : b - a;
		res = '0;
		if (acc_cnt < adsm_pkg::MAX_ITEMS) begin
			acc_sum += d;
			acc_sq += d * d;
			acc_cnt += 1;
		end else
			acc_drop = 1;
		if (!lst)
			return 0;
		n = acc_cnt;
		if (n != 0) begin
			m = acc_sum / n;
			r = acc_sum % n;
			t = acc_sq - m * (acc_sum + r);
			q1 = t / n;
			t1 = t % n;
			if (n * t1 < r * r && q1 > 0)
				q1 -= 1;
			res.mean = m[15:0];
			res.rms = 16'(isqrt(acc_sq / n));
			res.var_q = q1[31:0];
			res.sd = 16'(isqrt({32'd0, q1[31:0]}));
		end
		res.total = n[18:0];
		res.ovf = acc_drop;
		acc_sum = 0;
		acc_sq = 0;
		acc_cnt = 0;
		acc_drop = 0;
		return 1;
	endfunction

	task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic lst,
			input bit has_known, input stats_t known);
		stats_t res;
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		first_value <= a;
		second_value <= b;
		last <= lst;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		if (accumulate_pair(a, b, lst, res)) begin
			if (has_known && res != known) begin
				$display("%0t: predictor disagrees with table: exp %h got %h", $time, known, res);
				errors++;
			end
			stats_queue.push_back(res);
		end
	endtask

	always @(posedge clk) begin
		stats_t got, exp;
		if (result_valid && result_ready) begin
			got = '{mean, root_mean_square, variance, std_dev, item_total, overflowed};
			if (stats_queue.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				exp = stats_queue.pop_front();
				if (got != exp) begin
					$display("%0t: mismatch exp mean %h rms %h var %h sd %h n %h ovf %b",
						$time, exp.mean, exp.rms, exp.var_q, exp.sd, exp.total, exp.ovf);
					$display("%0t:          got mean %h rms %h var %h sd %h n %h ovf %b",
						$time, got.mean, got.rms, got.var_q, got.sd, got.total, got.ovf);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_off)
			result_ready <= 1'b0;
		else
			result_ready <= ($urandom_range(99) >= recv_stall);
	end

	task automatic add_row(input logic [15:0] a, input logic [15:0] b, input logic lst,
			input bit hk, input stats_t k);
		row_t rw;
		rw.a = a;
		rw.b = b;
		rw.lst = lst;
		rw.has_known = hk;
		rw.known = k;
		rows.push_back(rw);
	endtask

	task automatic random_sets(input int pairs);
		int sent, len;
		logic [15:0] a, b;
		sent = 0;
		while (sent < pairs) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				a = 16'($urandom);
				case ($urandom_range(3))
					0: b = 16'($urandom);
					1: b = a ^ (16'd1 << $urandom_range(15));
					2: b = a + 16'($urandom_range(40));
					default: b = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				endcase
				send_pair(a, b, i == len - 1, 0, '0);
			end
			sent += len;
		end
	endtask

	initial begin
		stats_t z;
		z = '0;
		acc_sum = 0;
		acc_sq = 0;
		acc_cnt = 0;
		acc_drop = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single pairs, extremes
		add_row(16'h0000, 16'h0000, 1, 1, '{16'h0, 16'h0, 32'h0, 16'h0, 19'd1, 1'b0});
		add_row(16'hFFFF, 16'h0000, 1, 1,
			'{16'hFFFF, 16'hFFFF, 32'h0, 16'h0, 19'd1, 1'b0});
		add_row(16'h0000, 16'hFFFF, 1, 1,
			'{16'hFFFF, 16'hFFFF, 32'h0, 16'h0, 19'd1, 1'b0});
		add_row(16'h1234, 16'h1234, 1, 1, '{16'h0, 16'h0, 32'h0, 16'h0, 19'd1, 1'b0});
		// two-pair set, 0 and 65535: maximum spread
		add_row(16'h0000, 16'h0000, 0, 0, z);
		add_row(16'hFFFF, 16'h0000, 1, 0, z);
		add_row(16'hAAAA, 16'h5555, 0, 0, z);
		add_row(16'h5555, 16'hAAAA, 0, 0, z);
		add_row(16'h0001, 16'hFFFE, 1, 0, z);
		add_row(16'h8000, 16'h7FFF, 0, 0, z);
		add_row(16'h0003, 16'h0000, 0, 0, z);
		add_row(16'h0000, 16'h0004, 1, 0, z);
		foreach (rows[i])
			send_pair(rows[i].a, rows[i].b, rows[i].lst, rows[i].has_known, rows[i].known);

		recv_stall = 0; send_idle = 0;
		random_sets(350);
		send_idle = 50;
		random_sets(300);
		send_idle = 0; recv_stall = 50;
		random_sets(300);
		send_idle = 6; recv_stall = 6;
		random_sets(250);

		// long receiver hold-off while the sender keeps offering
		send_idle = 0; recv_stall = 0;
		hold_off = 1;
		fork
			begin
				random_sets(150);
				item_valid <= 1'b0;
			end
			begin
				repeat (1500) @(posedge clk);
				hold_off = 0;
			end
		join
		@(posedge clk);

		random_sets(20);
		item_valid <= 1'b0;

		while (stats_queue.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("abs_difference_statistics test passed");
		else
			$display("abs_difference_statistics test failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("abs_difference_statistics test failed");
		$finish;
	end

endmodule
